### src/grs_pkg.sv
package grs_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_GROUP_DEF = 16;
  localparam int GS_W = 5;
  localparam int IDX_W_MAX = 6;
  localparam int ADDR_W = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int APB_DATA_W = 32;
  localparam int OQ_DEPTH = 4;
  localparam int DESC_DEPTH = 2;

  localparam logic [REG_IDX_W-1:0] REG_GROUP_SIZE = '0;
  localparam logic [GS_W-1:0] GROUP_SIZE_RESET = GS_W'(1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         list_end;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_out;
    logic                         group_last;
    logic                         list_last;
  } out_item_t;

  typedef struct packed {
    logic                 bank;
    logic [IDX_W_MAX-1:0] last_idx;
    logic                 list_end;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

endpackage

### src/grs_ram.sv
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/grs_desc_fifo.sv
module grs_desc_fifo import grs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  desc_t wr_desc,
  input  logic  rd_en,
  output desc_t rd_desc,
  output logic  empty
);

  localparam int PW = (DESC_DEPTH > 1) ? $clog2(DESC_DEPTH) : 1;
  localparam int CW = $clog2(DESC_DEPTH + 1);

  desc_t          entries [DESC_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;

  assign empty   = (count == '0);
  assign rd_desc = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == PW'(DESC_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (rd_en) begin
        rptr <= (rptr == PW'(DESC_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (count == CW'(DESC_DEPTH)) |-> !wr_en || rd_en)
    else $error("descriptor queue overflow");

endmodule

### src/grs_front.sv
module grs_front import grs_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [GS_W-1:0]                 group_size,
  input  logic                            push,
  output logic                            full,
  input  in_item_t                        item,
  output logic                            wr_en,
  output logic [$clog2(MAX_GROUP):0]      wr_addr,
  output logic [DATA_WIDTH-1:0]           wr_data,
  output logic                            desc_push,
  output desc_t                           desc,
  input  release_t                        rel
);

  localparam int IDXW = $clog2(MAX_GROUP);
  localparam int CW   = $clog2(MAX_GROUP + 1);
  localparam int EW   = (CW > GS_W) ? CW : GS_W;

  logic [CW-1:0]   fill;
  logic            bank;
  logic [1:0]      busy;
  logic            accept;
  logic            close;
  logic [EW-1:0]   gs_x;
  logic [EW-1:0]   eff;
  logic [EW-1:0]   cnt_next;

  always_comb begin
    gs_x = EW'(group_size);
    if (gs_x == '0) begin
      eff = EW'(1);
    end else if (gs_x > EW'(MAX_GROUP)) begin
      eff = EW'(MAX_GROUP);
    end else begin
      eff = gs_x;
    end
    cnt_next = EW'(fill) + EW'(1);
  end

  assign full      = busy[bank];
  assign accept    = push && !full;
  assign close     = (cnt_next >= eff) || item.list_end;
  assign wr_en     = accept;
  assign wr_addr   = {bank, fill[IDXW-1:0]};
  assign wr_data   = item.value;
  assign desc_push = accept && close;

  always_comb begin
    desc.bank     = bank;
    desc.last_idx = IDX_W_MAX'(fill[IDXW-1:0]);
    desc.list_end = item.list_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      bank <= 1'b0;
      busy <= '0;
    end else begin
      if (accept) begin
        if (close) begin
          fill       <= '0;
          bank       <= !bank;
        end else begin
          fill <= fill + CW'(1);
        end
      end
      if (desc_push) begin
        busy[bank] <= 1'b1;
      end
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill < CW'(MAX_GROUP))
    else $error("fill count reached the bank size");

  assert property (@(posedge clk) disable iff (rst)
    desc_push |=> (fill == '0) && busy[$past(bank)] && (bank != $past(bank)))
    else $error("closed group did not hand over its bank");

endmodule

### src/grs_back.sv
module grs_back import grs_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       desc_empty,
  input  desc_t                      desc,
  output logic                       desc_pop,
  output logic                       rd_en,
  output logic [$clog2(MAX_GROUP):0] rd_addr,
  input  logic [DATA_WIDTH-1:0]      rd_data,
  output release_t                   rel,
  output logic                       empty,
  input  logic                       pop,
  output out_item_t                  result
);

  localparam int IDXW = $clog2(MAX_GROUP);
  localparam int OPW  = $clog2(OQ_DEPTH);
  localparam int OCW  = $clog2(OQ_DEPTH + 1);

  logic             active;
  logic             bank;
  logic [IDXW-1:0]  idx;
  logic             end_flag;
  logic             pending;
  logic             m_glast;
  logic             m_llast;
  logic             issue;
  logic             last_issue;
  logic             take;

  out_item_t        oq [OQ_DEPTH];
  logic [OPW-1:0]   owptr;
  logic [OPW-1:0]   orptr;
  logic [OCW-1:0]   occ;

  assign issue      = active && ((occ + OCW'(pending)) < OCW'(OQ_DEPTH));
  assign last_issue = issue && (idx == '0);
  assign desc_pop   = !desc_empty && (!active || last_issue);
  assign rd_en      = issue;
  assign rd_addr    = {bank, idx};
  assign rel.valid  = last_issue;
  assign rel.bank   = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      pending <= 1'b0;
    end else begin
      pending <= issue;
      if (desc_pop) begin
        active <= 1'b1;
      end else if (last_issue) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_pop) begin
      bank     <= desc.bank;
      idx      <= desc.last_idx[IDXW-1:0];
      end_flag <= desc.list_end;
    end else if (issue) begin
      idx <= idx - IDXW'(1);
    end
    if (issue) begin
      m_glast <= (idx == '0);
      m_llast <= (idx == '0) && end_flag;
    end
  end

  // result queue
  assign take   = pop && !empty;
  assign empty  = (occ == '0);
  assign result = oq[orptr];

  always_ff @(posedge clk) begin
    if (pending) begin
      oq[owptr] <= '{value_out: rd_data, group_last: m_glast, list_last: m_llast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr <= '0;
      orptr <= '0;
      occ   <= '0;
    end else begin
      if (pending) begin
        owptr <= owptr + OPW'(1);
      end
      if (take) begin
        orptr <= orptr + OPW'(1);
      end
      case ({pending, take})
        2'b10:   occ <= occ + OCW'(1);
        2'b01:   occ <= occ - OCW'(1);
        default: occ <= occ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (occ + OCW'(pending)) <= OCW'(OQ_DEPTH))
    else $error("result queue over-committed");

  assert property (@(posedge clk) disable iff (rst)
    pending |-> ($past(idx) == '0) == m_glast)
    else $error("group end flag out of step with read index");

endmodule

### src/group_reverse_stream.sv
// channel  | handshake          | payload
// ---------+--------------------+----------------------------------------
// input    | push / full        | item   (value, list_end)
// result   | pop / empty        | result (value_out, group_last, list_last)
// config   | APB psel..pready   | group_size at byte address 0
//
// Two banks of MAX_GROUP words: one bank fills while the other drains.
// A group of k words enters one word per accepted push and leaves through the
// RAM read at one word per cycle while the result queue has room.
// full rises while both banks hold groups not yet read out.
// rst is synchronous; it empties both banks and sets group_size to 1.
// A stalled result side holds up draining only, until the banks run out.
module group_reverse_stream import grs_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             result
);

  localparam int RAM_DEPTH = 2 << $clog2(MAX_GROUP);
  localparam int RAW       = $clog2(RAM_DEPTH);

  logic [GS_W-1:0]        group_size;
  logic                   reg_hit;
  logic                   wr_en;
  logic [RAW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic                   rd_en;
  logic [RAW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic                   desc_push;
  desc_t                  desc_in;
  logic                   desc_pop;
  desc_t                  desc_out;
  logic                   desc_empty;
  release_t               rel;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_GROUP_SIZE);
  assign prdata  = reg_hit ? APB_DATA_W'(group_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      group_size <= pwdata[GS_W-1:0];
    end
  end

  grs_front #(.MAX_GROUP(MAX_GROUP)) u_front (
    .clk        (clk),
    .rst        (rst),
    .group_size (group_size),
    .push       (push),
    .full       (full),
    .item       (item),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .desc_push  (desc_push),
    .desc       (desc_in),
    .rel        (rel)
  );

  grs_desc_fifo u_desc_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (desc_push),
    .wr_desc (desc_in),
    .rd_en   (desc_pop),
    .rd_desc (desc_out),
    .empty   (desc_empty)
  );

  grs_ram #(.WIDTH(DATA_WIDTH), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  grs_back #(.MAX_GROUP(MAX_GROUP)) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc_empty (desc_empty),
    .desc       (desc_out),
    .desc_pop   (desc_pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rel        (rel),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

endmodule
